/* rtl/mma_pkg.sv */
// shared constants, codes and types of the matrix multiply-accumulate core
package mma_pkg;

    localparam int MAX_DIM_DEF = 48;

    localparam int SIZE_W = 6;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd48;

    localparam int OP_W   = 3;
    localparam int IDX_IN_W = 6;
    localparam int AB_W   = 32;
    localparam int C_W    = 64;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 72;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_C  = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_C  = 3'd4;

    localparam logic KIND_DONE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_READ  = 3'd1;
    localparam logic [ST_W-1:0] ST_RUN   = 3'd2;
    localparam logic [ST_W-1:0] ST_DRAIN = 3'd3;
    localparam logic [ST_W-1:0] ST_FIN   = 3'd4;

    localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
    localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

/* rtl/mma_mac.sv */
// shared multiplier and saturating accumulator with the sticky saturation flag
module mma_mac import mma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mac_ctl              i_ctl,
    input  logic signed [AB_W-1:0] i_a,
    input  logic signed [AB_W-1:0] i_b,
    input  logic signed [C_W-1:0]  i_c,
    input  logic                  i_clr_sat,
    output logic                  o_wr,
    output logic signed [C_W-1:0]  o_sum,
    output logic                  o_sat
);

    t_mac_ctl              r_ctl1;
    t_mac_ctl              r_ctl2;
    logic signed [C_W-1:0] r_prod;
    logic signed [C_W-1:0] r_acc;
    logic signed [C_W-1:0] n_acc;
    logic                  r_sat;
    logic [C_W:0]          sum_ext;
    logic                  ovf;

    // one extra bit shows the overflow of the signed add
    always_comb begin
        sum_ext = {r_prod[C_W-1], r_prod} + {r_acc[C_W-1], r_acc};
        ovf     = sum_ext[C_W] != sum_ext[C_W-1];
        if (ovf) begin
            n_acc = sum_ext[C_W] ? C_MIN : C_MAX;
        end else begin
            n_acc = sum_ext[C_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_sat  <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            if (i_clr_sat) begin
                r_sat <= 1'b0;
            end else if (r_ctl2.valid && ovf) begin
                r_sat <= 1'b1;
            end
        end
    end

    // memory data lines up with r_ctl1
    always_ff @(posedge i_clk) begin
        if (r_ctl1.valid) begin
            r_prod <= i_a * i_b;
        end
        if (r_ctl2.valid) begin
            r_acc <= n_acc;
        end else if (r_ctl1.valid && r_ctl1.first) begin
            r_acc <= i_c;
        end
    end

    assign o_wr  = r_ctl2.valid && r_ctl2.last;
    assign o_sum = n_acc;
    assign o_sat = r_sat;

endmodule

/* rtl/mma_seq.sv */
// sequencer: walks i, j, k over the product and issues store addresses
module mma_seq import mma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go_compute,
    input  logic                              i_go_read,
    input  logic [$clog2(MAX_DIM+1)-1:0]      i_dim,
    input  logic                              i_wr_done,
    output logic [ST_W-1:0]                   o_state,
    output t_mac_ctl                          o_ctl,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_addr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_addr_b,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] o_addr_c
);

    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM+1);

    logic [ST_W-1:0]  r_state;
    logic [ST_W-1:0]  n_state;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] n_i;
    logic [IDX_W-1:0] n_j;
    logic [IDX_W-1:0] n_k;
    logic [DIM_W-1:0] dim_m1;
    logic             k_last;
    logic             j_last;
    logic             i_last;

    assign dim_m1 = i_dim - DIM_W'(1);
    assign k_last = DIM_W'(r_k) == dim_m1;
    assign j_last = DIM_W'(r_j) == dim_m1;
    assign i_last = DIM_W'(r_i) == dim_m1;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                if (i_go_compute) begin
                    n_state = (i_dim == '0) ? ST_FIN : ST_RUN;
                end else if (i_go_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_RUN: begin
                if (k_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                // wait for the element's final sum to be written back
                if (i_wr_done) begin
                    n_k     = '0;
                    n_state = ST_RUN;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_state = ST_FIN;
                        end else begin
                            n_i = r_i + IDX_W'(1);
                        end
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        o_ctl.valid = r_state == ST_RUN;
        o_ctl.first = r_k == '0;
        o_ctl.last  = k_last;
    end

    assign o_state  = r_state;
    assign o_addr_a = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign o_addr_b = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);
    assign o_addr_c = ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j);

endmodule

/* rtl/matrix_multiply_accumulate_core.sv */
// Square matrix multiply-accumulate core, C = C + A*B over the leading n-by-n corner
// (n = matrix_size, clamped to MAX_DIM), A and B signed Q16.16, C signed Q32.32 with
// saturating sums and a sticky saturation flag that any in-range C load clears.
// A compute item holds the core while one multiplier and one accumulator do every
// multiply-accumulate, one per cycle except while an element drains, and each element
// of C waits in the drain state for the multiply and add stages to empty before it
// is written back. The stores are undefined until written, so every entry used must
// be loaded first.
module matrix_multiply_accumulate_core import mma_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SIZE_W-1:0]      i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row, col, ab_value, c_value, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // element, saturated, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // kind
    output logic [0:0]             m_axis_tuser
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int DIM_W  = $clog2(MAX_DIM+1);

    logic [OP_W-1:0]        in_op;
    logic [IDX_IN_W-1:0]    in_row;
    logic [IDX_IN_W-1:0]    in_col;
    logic signed [AB_W-1:0] in_ab;
    logic signed [C_W-1:0]  in_c;
    logic                   in_ok;
    logic [ADDR_W-1:0]      in_addr;
    logic                   in_fire;

    logic [SIZE_W-1:0]      r_size;
    logic [DIM_W-1:0]       dim;

    logic [ST_W-1:0]        seq_state;
    t_mac_ctl               seq_ctl;
    logic [ADDR_W-1:0]      seq_addr_a;
    logic [ADDR_W-1:0]      seq_addr_b;
    logic [ADDR_W-1:0]      seq_addr_c;
    logic                   seq_idle;

    logic                   mac_wr;
    logic signed [C_W-1:0]  mac_sum;
    logic                   mac_sat;

    logic signed [AB_W-1:0] mem_a [CELLS];
    logic signed [AB_W-1:0] mem_b [CELLS];
    logic signed [C_W-1:0]  mem_c [CELLS];
    logic signed [AB_W-1:0] r_a_q;
    logic signed [AB_W-1:0] r_b_q;
    logic signed [C_W-1:0]  r_c_q;
    logic [ADDR_W-1:0]      c_rd_addr;
    logic [ADDR_W-1:0]      c_wr_addr;
    logic signed [C_W-1:0]  c_wr_data;
    logic                   c_wr_en;
    logic                   load_c;

    logic                   r_rd_ok;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic signed [C_W-1:0]  r_out_elem;
    logic                   r_out_sat;

    assign in_op  = s_axis_tuser;
    assign in_row = s_axis_tdata[5:0];
    assign in_col = s_axis_tdata[11:6];
    assign in_ab  = s_axis_tdata[43:12];
    assign in_c   = s_axis_tdata[107:44];

    assign in_ok   = ({1'b0, in_row} < 7'(MAX_DIM)) && ({1'b0, in_col} < 7'(MAX_DIM));
    assign in_addr = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

    assign seq_idle      = seq_state == ST_IDLE;
    assign s_axis_tready = seq_idle && (!r_out_valid || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    assign dim = ({1'b0, r_size} > 7'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(r_size);

    mma_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go_compute (in_fire && in_op == OP_COMPUTE),
        .i_go_read    (in_fire && in_op == OP_READ_C),
        .i_dim        (dim),
        .i_wr_done    (mac_wr),
        .o_state      (seq_state),
        .o_ctl        (seq_ctl),
        .o_addr_a     (seq_addr_a),
        .o_addr_b     (seq_addr_b),
        .o_addr_c     (seq_addr_c)
    );

    assign load_c = in_fire && in_op == OP_LOAD_C && in_ok;

    mma_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (seq_ctl),
        .i_a       (r_a_q),
        .i_b       (r_b_q),
        .i_c       (r_c_q),
        .i_clr_sat (load_c),
        .o_wr      (mac_wr),
        .o_sum     (mac_sum),
        .o_sat     (mac_sat)
    );

    // element stores
    always_ff @(posedge i_clk) begin
        if (in_fire && in_op == OP_LOAD_A && in_ok) begin
            mem_a[in_addr] <= in_ab;
        end
        r_a_q <= mem_a[seq_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && in_op == OP_LOAD_B && in_ok) begin
            mem_b[in_addr] <= in_ab;
        end
        r_b_q <= mem_b[seq_addr_b];
    end

    // loads only happen while idle, write-backs only while computing
    always_comb begin
        c_wr_en   = load_c || mac_wr;
        c_wr_addr = mac_wr ? seq_addr_c : in_addr;
        c_wr_data = mac_wr ? mac_sum : in_c;
        if (seq_idle) begin
            c_rd_addr = in_ok ? in_addr : '0;
        end else begin
            c_rd_addr = seq_addr_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            mem_c[c_wr_addr] <= c_wr_data;
        end
        r_c_q <= mem_c[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_ok <= in_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_state == ST_READ || seq_state == ST_FIN) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_state == ST_READ) begin
            r_out_kind <= KIND_READ;
            r_out_elem <= r_rd_ok ? r_c_q : '0;
            r_out_sat  <= mac_sat;
        end else if (seq_state == ST_FIN) begin
            r_out_kind <= KIND_DONE;
            r_out_elem <= '0;
            r_out_sat  <= mac_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_sat, r_out_elem};
    assign m_axis_tuser  = r_out_kind;

    a_wr_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_wr |-> seq_state == ST_DRAIN)
        else $error("write-back of C outside the drain state");

    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_DONE) |-> r_out_elem == '0)
        else $error("done item carries a nonzero element");

    a_fin_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_state == ST_FIN |=> r_out_valid && r_out_kind == KIND_DONE)
        else $error("finished compute did not post a done item");

endmodule
